// ===== sv/c65x_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// c65x_pkg
// Shared types and constants for the 6502 execute unit.
// ---------------------------------------------------------------------------
package c65x_pkg;

	localparam int RAM_ADDR_BITS = 11;

	typedef enum logic [1:0] {
		CMD_EXEC  = 2'd0,
		CMD_HWR   = 2'd1,
		CMD_HRD   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [5:0] {
		I_LDA = 6'd0,  I_LDX = 6'd1,  I_LDY = 6'd2,  I_STA = 6'd3,  I_STX = 6'd4,
		I_STY = 6'd5,  I_TAX = 6'd6,  I_TAY = 6'd7,  I_TSX = 6'd8,  I_TXA = 6'd9,
		I_TXS = 6'd10, I_TYA = 6'd11, I_ADC = 6'd12, I_DEC = 6'd13, I_DEX = 6'd14,
		I_DEY = 6'd15, I_INC = 6'd16, I_INX = 6'd17, I_INY = 6'd18, I_SBC = 6'd19,
		I_AND = 6'd20, I_ASL = 6'd21, I_BIT = 6'd22, I_EOR = 6'd23, I_LSR = 6'd24,
		I_ORA = 6'd25, I_ROL = 6'd26, I_ROR = 6'd27, I_BCC = 6'd28, I_BCS = 6'd29,
		I_BEQ = 6'd30, I_BMI = 6'd31, I_BNE = 6'd32, I_BPL = 6'd33, I_BVC = 6'd34,
		I_BVS = 6'd35, I_JMP = 6'd36, I_JSR = 6'd37, I_RTI = 6'd38, I_RTS = 6'd39,
		I_CLC = 6'd40, I_CLD = 6'd41, I_CLI = 6'd42, I_CLV = 6'd43, I_CMP = 6'd44,
		I_CPX = 6'd45, I_CPY = 6'd46, I_SEC = 6'd47, I_SED = 6'd48, I_SEI = 6'd49,
		I_BRK = 6'd50, I_NOP = 6'd51
	} instr_t;

	localparam logic [1:0] MODE_IMM = 2'd0;
	localparam logic [1:0] MODE_ACC = 2'd1;

	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] P_RESET  = 8'h24;
	localparam logic [7:0] P_BRK    = 8'h30;
	localparam logic [7:0] STACK_PAGE = 8'h01;

	localparam int FC = 0;
	localparam int FZ = 1;
	localparam int FI = 2;
	localparam int FD = 3;
	localparam int FV = 6;
	localparam int FN = 7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_PUSH1,
		ST_PUSH2,
		ST_PUSH3,
		ST_PULL1,
		ST_PULL2,
		ST_PULL3,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;       // capture input item
		logic       mem_rd;     // read RAM at operand address
		logic       exec;       // apply single-step instruction result
		logic       push;       // write stack byte and decrement SP
		logic [1:0] push_sel;   // 0: PC high, 1: PC low, 2: P
		logic       pull_rd;    // increment SP and read stack
		logic [1:0] pull_sel;   // 0: P, 1: PC low, 2: PC high
		logic       pull_wr;    // write pulled byte into its register
		logic       out_load;   // load output register
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic [5:0] instr;
	} sts_t;

endpackage
`default_nettype wire

// ===== sv/cpu6502_execute_unit.sv =====
`default_nettype none
// Each item is accepted in idle and passes through read, execute, any stack
// pushes or pulls, and done before its result is loaded; the data RAM is
// single-port (one read, one write or one stack access per cycle), and a new
// item is taken only once the previous one has reached the output register.
// The output register lets a result wait while the next item is taken.
// Reset clears A, X, Y, PC, sets SP to 0xFD and P to 0x24; RAM is not cleared.
// ---------------------------------------------------------------------------
// cpu6502_execute_unit
// Executes one decoded 6502 instruction or host RAM access per item.
// ---------------------------------------------------------------------------
module cpu6502_execute_unit import c65x_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [5:0]  instr,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] operand,
	input  wire logic [7:0]  branch_offset,
	input  wire logic [7:0]  host_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       acc,
	output logic [7:0]       x_reg,
	output logic [7:0]       y_reg,
	output logic [7:0]       stack_ptr,
	output logic [7:0]       status,
	output logic [15:0]      prog_counter,
	output logic [7:0]       host_read_data
);

	ctl_t ctl;
	sts_t sts;

	// Sequencer
	c65x_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .ctl
	);

	// Registers, ALU and RAM
	c65x_datapath u_dp (
		.clk, .arst_n, .ctl, .sts, .cmd, .instr, .mode, .operand,
		.branch_offset, .host_data, .acc, .x_reg, .y_reg, .stack_ptr,
		.status, .prog_counter, .host_read_data
	);

endmodule
`default_nettype wire

// ===== sv/c65x_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// c65x_datapath
// Register file, ALU, single-port data RAM and output register.
// ---------------------------------------------------------------------------
module c65x_datapath import c65x_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_t        ctl,
	output sts_t             sts,
	input  wire logic [1:0]  cmd,
	input  wire logic [5:0]  instr,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] operand,
	input  wire logic [7:0]  branch_offset,
	input  wire logic [7:0]  host_data,
	output logic [7:0]       acc,
	output logic [7:0]       x_reg,
	output logic [7:0]       y_reg,
	output logic [7:0]       stack_ptr,
	output logic [7:0]       status,
	output logic [15:0]      prog_counter,
	output logic [7:0]       host_read_data
);

	logic [7:0]  mem_q [0:(1 << RAM_ADDR_BITS) - 1];
	logic [1:0]  cmd_q;
	logic [5:0]  instr_q;
	logic [1:0]  mode_q;
	logic [15:0] opd_q;
	logic [7:0]  off_q;
	logic [7:0]  hdata_q;
	logic [7:0]  rdata_q;
	logic [7:0]  a_q, x_q, y_q, sp_q, p_q;
	logic [15:0] pc_q;
	logic [7:0]  hrd_q;

	logic [RAM_ADDR_BITS-1:0] opd_addr;
	logic [RAM_ADDR_BITS-1:0] stk_addr;
	logic [RAM_ADDR_BITS-1:0] wr_addr;
	logic [RAM_ADDR_BITS-1:0] rd_addr;
	logic [7:0]  wr_data;
	logic        wr_en;
	logic [7:0]  sp_inc;
	logic [15:0] pc_ret;

	// ALU results
	logic [7:0]  m, v, r, a_n, x_n, y_n, p_n;
	logic [15:0] pc_n;
	logic        mem_wr_n;
	logic [8:0]  sum;
	logic [7:0]  addend;
	logic        taken;

	assign sts.cmd   = cmd_q;
	assign sts.instr = instr_q;

	assign opd_addr = opd_q[RAM_ADDR_BITS-1:0];
	assign sp_inc   = sp_q + 8'd1;
	assign pc_ret   = pc_q + 16'd2;

	// Stack address in page one, masked to RAM size
	always_comb begin
		logic [15:0] sa;
		sa = {STACK_PAGE, (ctl.pull_rd ? sp_inc : sp_q)};
		stk_addr = sa[RAM_ADDR_BITS-1:0];
	end

	assign rd_addr = ctl.pull_rd ? stk_addr : opd_addr;

	// Single-step instruction evaluation
	always_comb begin
		m = (mode_q == MODE_IMM) ? opd_q[7:0] : rdata_q;
		v = (mode_q == MODE_ACC) ? a_q : rdata_q;
		a_n = a_q; x_n = x_q; y_n = y_q; p_n = p_q; pc_n = pc_q;
		r = 8'd0; mem_wr_n = 1'b0; taken = 1'b0;
		addend = (instr_q == I_SBC) ? ~m : m;
		sum = {1'b0, a_q} + {1'b0, addend} + {8'd0, p_q[FC]};
		case (instr_q)
			I_LDA: begin a_n = m; r = m; end
			I_LDX: begin x_n = m; r = m; end
			I_LDY: begin y_n = m; r = m; end
			I_STA: begin r = a_q; mem_wr_n = 1'b1; end
			I_STX: begin r = x_q; mem_wr_n = 1'b1; end
			I_STY: begin r = y_q; mem_wr_n = 1'b1; end
			I_TAX: begin x_n = a_q; r = a_q; end
			I_TAY: begin y_n = a_q; r = a_q; end
			I_TSX: begin x_n = sp_q; r = sp_q; end
			I_TXA: begin a_n = x_q; r = x_q; end
			I_TYA: begin a_n = y_q; r = y_q; end
			I_ADC, I_SBC: begin
				r = sum[7:0]; a_n = r;
				p_n[FC] = sum[8];
				p_n[FV] = ~(a_q[7] ^ addend[7]) & (a_q[7] ^ r[7]);
			end
			I_DEC: begin r = rdata_q - 8'd1; mem_wr_n = 1'b1; end
			I_INC: begin r = rdata_q + 8'd1; mem_wr_n = 1'b1; end
			I_DEX: begin r = x_q - 8'd1; x_n = r; end
			I_DEY: begin r = y_q - 8'd1; y_n = r; end
			I_INX: begin r = x_q + 8'd1; x_n = r; end
			I_INY: begin r = y_q + 8'd1; y_n = r; end
			I_AND: begin r = a_q & m; a_n = r; end
			I_EOR: begin r = a_q ^ m; a_n = r; end
			I_ORA: begin r = a_q | m; a_n = r; end
			I_ASL, I_LSR, I_ROL, I_ROR: begin
				case (instr_q)
					I_ASL: begin p_n[FC] = v[7]; r = {v[6:0], 1'b0}; end
					I_LSR: begin p_n[FC] = v[0]; r = {1'b0, v[7:1]}; end
					I_ROL: begin p_n[FC] = v[7]; r = {v[6:0], p_q[FC]}; end
					default: begin p_n[FC] = v[0]; r = {p_q[FC], v[7:1]}; end
				endcase
				if (mode_q == MODE_ACC) begin
					a_n = r;
				end else begin
					mem_wr_n = 1'b1;
				end
			end
			I_CMP, I_CPX, I_CPY: begin
				logic [7:0] reg_v;
				reg_v = (instr_q == I_CMP) ? a_q : ((instr_q == I_CPX) ? x_q : y_q);
				p_n[FC] = reg_v >= m;
				r = reg_v - m;
			end
			I_BCC: taken = ~p_q[FC];
			I_BCS: taken = p_q[FC];
			I_BEQ: taken = p_q[FZ];
			I_BMI: taken = p_q[FN];
			I_BNE: taken = ~p_q[FZ];
			I_BPL: taken = ~p_q[FN];
			I_BVC: taken = ~p_q[FV];
			I_BVS: taken = p_q[FV];
			// JSR loads PC only after its return address is pushed
			I_JMP: pc_n = opd_q;
			I_CLC: p_n[FC] = 1'b0;
			I_CLD: p_n[FD] = 1'b0;
			I_CLI: p_n[FI] = 1'b0;
			I_CLV: p_n[FV] = 1'b0;
			I_SEC: p_n[FC] = 1'b1;
			I_SED: p_n[FD] = 1'b1;
			I_SEI: p_n[FI] = 1'b1;
			default: ;
		endcase
		// Branch target
		if (instr_q >= I_BCC && instr_q <= I_BVS) begin
			pc_n = pc_ret + (taken ? {{8{off_q[7]}}, off_q} : 16'd0);
		end
		// N and Z from the result byte; BIT sets N and V from memory, Z from A AND memory
		case (instr_q)
			I_LDA, I_LDX, I_LDY, I_TAX, I_TAY, I_TSX, I_TXA, I_TYA, I_ADC, I_SBC,
			I_DEC, I_INC, I_DEX, I_DEY, I_INX, I_INY, I_AND, I_EOR, I_ORA,
			I_ASL, I_LSR, I_ROL, I_ROR, I_CMP, I_CPX, I_CPY: begin
				p_n[FN] = r[7];
				p_n[FZ] = (r == 8'd0);
			end
			I_BIT: begin
				p_n[FN] = rdata_q[7];
				p_n[FV] = rdata_q[6];
				p_n[FZ] = ((a_q & rdata_q) == 8'd0);
			end
			default: ;
		endcase
	end

	// RAM write port select
	always_comb begin
		wr_en = 1'b0;
		wr_addr = opd_addr;
		wr_data = r;
		if (ctl.push) begin
			wr_en = 1'b1;
			wr_addr = stk_addr;
			case (ctl.push_sel)
				2'd0:    wr_data = (instr_q == I_BRK) ? pc_ret[15:8] : pc_q[15:8];
				2'd1:    wr_data = (instr_q == I_BRK) ? pc_ret[7:0] : pc_q[7:0];
				default: wr_data = p_q | P_BRK;
			endcase
		end else if (ctl.exec && cmd_q == CMD_EXEC && mem_wr_n) begin
			wr_en = 1'b1;
		end else if (ctl.exec && cmd_q == CMD_HWR) begin
			wr_en = 1'b1;
			wr_data = hdata_q;
		end
	end

	// Data RAM
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.mem_rd || ctl.pull_rd) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// Capture input item
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd;
			instr_q <= instr;
			mode_q  <= mode;
			opd_q   <= operand;
			off_q   <= branch_offset;
			hdata_q <= host_data;
		end
	end

	// Architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0;
			sp_q <= SP_RESET; p_q <= P_RESET; pc_q <= 16'd0;
			hrd_q <= 8'd0;
		end else begin
			if (ctl.load) begin
				hrd_q <= 8'd0;
			end
			if (ctl.exec && cmd_q == CMD_EXEC) begin
				a_q <= a_n; x_q <= x_n; y_q <= y_n; p_q <= p_n; pc_q <= pc_n;
				if (instr_q == I_TXS) begin
					sp_q <= x_q;
				end
			end
			if (ctl.exec && cmd_q == CMD_HRD) begin
				hrd_q <= rdata_q;
			end
			if (ctl.push) begin
				sp_q <= sp_q - 8'd1;
				if (ctl.push_sel == 2'd2) begin
					p_q[FI] <= 1'b1;
				end
				// Jump once the low return byte goes out
				if (ctl.push_sel == 2'd1 && instr_q == I_JSR) begin
					pc_q <= opd_q;
				end
			end
			if (ctl.pull_rd) begin
				sp_q <= sp_inc;
			end
			if (ctl.pull_wr) begin
				case (ctl.pull_sel)
					2'd0:    p_q <= rdata_q;
					2'd1:    pc_q[7:0] <= rdata_q;
					default: pc_q[15:8] <= rdata_q;
				endcase
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			acc <= a_q; x_reg <= x_q; y_reg <= y_q; stack_ptr <= sp_q;
			status <= p_q; prog_counter <= pc_q; host_read_data <= hrd_q;
		end
	end

endmodule
`default_nettype wire

// ===== sv/c65x_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// c65x_ctrl
// Sequencer: memory read, execute, stack pushes and pulls, output handshake.
// ---------------------------------------------------------------------------
module c65x_ctrl import c65x_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output ctl_t      ctl
);

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   pull_pend_q;
	logic [1:0] pull_sel_q;
	logic   in_acc, out_acc, is_jsr, is_brk, is_rti, is_rts;

	assign is_jsr = sts.cmd == CMD_EXEC && sts.instr == I_JSR;
	assign is_brk = sts.cmd == CMD_EXEC && sts.instr == I_BRK;
	assign is_rti = sts.cmd == CMD_EXEC && sts.instr == I_RTI;
	assign is_rts = sts.cmd == CMD_EXEC && sts.instr == I_RTS;

	assign out_valid = out_valid_q;
	assign out_acc   = out_valid_q && !out_stall;
	// Take a new item while the previous result waits, as long as idle
	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_n = ST_READ;
			ST_READ:  state_n = ST_EXEC;
			ST_EXEC: begin
				if (is_jsr || is_brk) state_n = ST_PUSH1;
				else if (is_rti)      state_n = ST_PULL1;
				else if (is_rts)      state_n = ST_PULL2;
				else                  state_n = ST_DONE;
			end
			ST_PUSH1: state_n = ST_PUSH2;
			ST_PUSH2: state_n = is_brk ? ST_PUSH3 : ST_DONE;
			ST_PUSH3: state_n = ST_DONE;
			ST_PULL1: state_n = ST_PULL2;
			ST_PULL2: state_n = ST_PULL3;
			ST_PULL3: state_n = ST_DONE;
			// Wait for the last pulled byte to land before loading the result
			ST_DONE:  if (!pull_pend_q && (!out_valid_q || out_acc)) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctl = '0;
		ctl.pull_sel = pull_sel_q;
		ctl.pull_wr  = pull_pend_q;
		case (state_q)
			ST_IDLE:  ctl.load = in_acc;
			ST_READ:  ctl.mem_rd = 1'b1;
			ST_EXEC:  ctl.exec = !(is_rti || is_rts);
			ST_PUSH1: begin ctl.push = 1'b1; ctl.push_sel = 2'd0; end
			ST_PUSH2: begin ctl.push = 1'b1; ctl.push_sel = 2'd1; end
			ST_PUSH3: begin ctl.push = 1'b1; ctl.push_sel = 2'd2; end
			ST_PULL1, ST_PULL2, ST_PULL3: ctl.pull_rd = 1'b1;
			ST_DONE:  ctl.out_load = !pull_pend_q && (!out_valid_q || out_acc);
			default: ;
		endcase
	end

	// Pull write-back follows the stack read in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pull_pend_q <= 1'b0;
			pull_sel_q  <= 2'd0;
		end else begin
			state_q     <= state_n;
			pull_pend_q <= ctl.pull_rd;
			case (state_q)
				ST_PULL1: pull_sel_q <= 2'd0;
				ST_PULL2: pull_sel_q <= 2'd1;
				default:  pull_sel_q <= 2'd2;
			endcase
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== test/tb_cpu6502_execute_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cpu6502_execute_unit
// Self-checking bench for the 6502 execute unit. After a first directed row,
// pages zero and one of the RAM are loaded with random bytes through host
// writes. The rest of the directed table and then random instructions follow.
// A local register and RAM model predicts every result but for typed rows,
// whose values the table gives. Both handshakes see random gaps and stalls.
module tb_cpu6502_execute_unit;
	import c65x_pkg::*;

	localparam int RAM_WORDS   = 1 << RAM_ADDR_BITS;
	localparam int LOAD_WORDS  = 512;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int N_RANDOM    = 500;

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  p;
		logic [15:0] pc;
		logic [7:0]  rd;
	} regs_t;

	typedef struct {
		cmd_t        c;
		logic [5:0]  op;
		logic [1:0]  md;
		logic [15:0] opd;
		logic [7:0]  ofs;
		logic [7:0]  hd;
		bit          typed;
		regs_t       want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [5:0]  instr;
	logic [1:0]  mode;
	logic [15:0] operand;
	logic [7:0]  branch_offset;
	logic [7:0]  host_data;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  acc;
	logic [7:0]  x_reg;
	logic [7:0]  y_reg;
	logic [7:0]  stack_ptr;
	logic [7:0]  status;
	logic [15:0] prog_counter;
	logic [7:0]  host_read_data;

	// Model state
	logic [7:0]  m_a, m_x, m_y, m_sp, m_p;
	logic [15:0] m_pc;
	logic [7:0]  m_ram [RAM_WORDS];

	regs_t       pending_regs[$];
	row_t        dir_rows[$];
	bit          typed_now;
	regs_t       typed_want;
	int          n_accepted;
	int          n_errors;
	int          n_cycles;
	bit          calm;

	cpu6502_execute_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .instr(instr), .mode(mode), .operand(operand),
		.branch_offset(branch_offset), .host_data(host_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.acc(acc), .x_reg(x_reg), .y_reg(y_reg), .stack_ptr(stack_ptr),
		.status(status), .prog_counter(prog_counter),
		.host_read_data(host_read_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [RAM_ADDR_BITS-1:0] ram_index(logic [15:0] ad);
		return ad[RAM_ADDR_BITS-1:0];
	endfunction

	task automatic stack_push(logic [7:0] v);
		m_ram[ram_index({STACK_PAGE, m_sp})] = v;
		m_sp = m_sp - 8'd1;
	endtask

	task automatic stack_pull(output logic [7:0] v);
		m_sp = m_sp + 8'd1;
		v = m_ram[ram_index({STACK_PAGE, m_sp})];
	endtask

	task automatic set_nz(logic [7:0] v);
		m_p[FN] = v[7];
		m_p[FZ] = (v == 8'd0);
	endtask

	task automatic add_carry(logic [7:0] m);
		logic [8:0] s;
		logic [7:0] r;
		s = {1'b0, m_a} + {1'b0, m} + {8'd0, m_p[FC]};
		r = s[7:0];
		m_p[FC] = s[8];
		m_p[FV] = (~(m_a[7] ^ m[7])) & (m_a[7] ^ r[7]);
		set_nz(r);
		m_a = r;
	endtask

	task automatic compare_reg(logic [7:0] rg, logic [7:0] m);
		m_p[FC] = (rg >= m);
		set_nz(rg - m);
	endtask

	task automatic take_branch(bit taken, logic [7:0] ofs);
		m_pc = m_pc + 16'd2 + (taken ? {{8{ofs[7]}}, ofs} : 16'd0);
	endtask

	// Advance the model by one item and return the registers it shows
	task automatic exec_item(input logic [1:0] c, input logic [5:0] op,
			input logic [1:0] md, input logic [15:0] opd,
			input logic [7:0] ofs, input logic [7:0] hd, output regs_t res);
		logic [7:0] m, v, r, lo, hi, cy;
		logic [15:0] ret;
		logic [RAM_ADDR_BITS-1:0] ix;
		ix = ram_index(opd);
		res.rd = 8'd0;
		if (c == CMD_HWR) begin
			m_ram[ix] = hd;
		end else if (c == CMD_HRD) begin
			res.rd = m_ram[ix];
		end else if (c == CMD_EXEC) begin
			m = (md == MODE_IMM) ? opd[7:0] : m_ram[ix];
			v = (md == MODE_ACC) ? m_a : m_ram[ix];
			cy = {7'd0, m_p[FC]};
			case (op)
				I_LDA: begin m_a = m; set_nz(m); end
				I_LDX: begin m_x = m; set_nz(m); end
				I_LDY: begin m_y = m; set_nz(m); end
				I_STA: m_ram[ix] = m_a;
				I_STX: m_ram[ix] = m_x;
				I_STY: m_ram[ix] = m_y;
				I_TAX: begin m_x = m_a; set_nz(m_x); end
				I_TAY: begin m_y = m_a; set_nz(m_y); end
				I_TSX: begin m_x = m_sp; set_nz(m_x); end
				I_TXA: begin m_a = m_x; set_nz(m_a); end
				I_TXS: m_sp = m_x;
				I_TYA: begin m_a = m_y; set_nz(m_a); end
				I_ADC: add_carry(m);
				I_SBC: add_carry(~m);
				I_DEC: begin r = m_ram[ix] - 8'd1; m_ram[ix] = r; set_nz(r); end
				I_INC: begin r = m_ram[ix] + 8'd1; m_ram[ix] = r; set_nz(r); end
				I_DEX: begin m_x = m_x - 8'd1; set_nz(m_x); end
				I_DEY: begin m_y = m_y - 8'd1; set_nz(m_y); end
				I_INX: begin m_x = m_x + 8'd1; set_nz(m_x); end
				I_INY: begin m_y = m_y + 8'd1; set_nz(m_y); end
				I_AND: begin m_a = m_a & m; set_nz(m_a); end
				I_EOR: begin m_a = m_a ^ m; set_nz(m_a); end
				I_ORA: begin m_a = m_a | m; set_nz(m_a); end
				I_BIT: begin
					r = m_ram[ix];
					m_p[FN] = r[7];
					m_p[FV] = r[6];
					m_p[FZ] = ((m_a & r) == 8'd0);
				end
				I_ASL, I_LSR, I_ROL, I_ROR: begin
					case (op)
						I_ASL: begin m_p[FC] = v[7]; r = v << 1; end
						I_LSR: begin m_p[FC] = v[0]; r = v >> 1; end
						I_ROL: begin m_p[FC] = v[7]; r = (v << 1) | cy; end
						default: begin m_p[FC] = v[0]; r = (v >> 1) | (cy << 7); end
					endcase
					set_nz(r);
					if (md == MODE_ACC) m_a = r;
					else m_ram[ix] = r;
				end
				I_BCC: take_branch(!m_p[FC], ofs);
				I_BCS: take_branch(m_p[FC], ofs);
				I_BEQ: take_branch(m_p[FZ], ofs);
				I_BMI: take_branch(m_p[FN], ofs);
				I_BNE: take_branch(!m_p[FZ], ofs);
				I_BPL: take_branch(!m_p[FN], ofs);
				I_BVC: take_branch(!m_p[FV], ofs);
				I_BVS: take_branch(m_p[FV], ofs);
				I_JMP: m_pc = opd;
				I_JSR: begin
					stack_push(m_pc[15:8]);
					stack_push(m_pc[7:0]);
					m_pc = opd;
				end
				I_RTI: begin
					stack_pull(m_p);
					stack_pull(lo);
					stack_pull(hi);
					m_pc = {hi, lo};
				end
				I_RTS: begin
					stack_pull(lo);
					stack_pull(hi);
					m_pc = {hi, lo};
				end
				I_CLC: m_p[FC] = 1'b0;
				I_CLD: m_p[FD] = 1'b0;
				I_CLI: m_p[FI] = 1'b0;
				I_CLV: m_p[FV] = 1'b0;
				I_CMP: compare_reg(m_a, m);
				I_CPX: compare_reg(m_x, m);
				I_CPY: compare_reg(m_y, m);
				I_SEC: m_p[FC] = 1'b1;
				I_SED: m_p[FD] = 1'b1;
				I_SEI: m_p[FI] = 1'b1;
				I_BRK: begin
					ret = m_pc + 16'd2;
					stack_push(ret[15:8]);
					stack_push(ret[7:0]);
					stack_push(m_p | P_BRK);
					m_p[FI] = 1'b1;
				end
				default: ;
			endcase
		end
		res.a = m_a;
		res.x = m_x;
		res.y = m_y;
		res.sp = m_sp;
		res.p = m_p;
		res.pc = m_pc;
	endtask

	// Predict on every accepted input item
	always @(posedge clk) begin
		regs_t r;
		if (arst_n && in_valid && !in_stall) begin
			exec_item(cmd, instr, mode, operand, branch_offset, host_data, r);
			pending_regs.push_back(typed_now ? typed_want : r);
			n_accepted++;
		end
	end

	// Check every accepted result against the oldest expectation
	always @(posedge clk) begin
		regs_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{acc, x_reg, y_reg, stack_ptr, status, prog_counter, host_read_data};
			if (pending_regs.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				n_errors++;
			end else begin
				want = pending_regs.pop_front();
				if (got.a !== want.a)
					$display("%0t: acc exp %h got %h", $time, want.a, got.a);
				if (got.x !== want.x)
					$display("%0t: x_reg exp %h got %h", $time, want.x, got.x);
				if (got.y !== want.y)
					$display("%0t: y_reg exp %h got %h", $time, want.y, got.y);
				if (got.sp !== want.sp)
					$display("%0t: stack_ptr exp %h got %h", $time, want.sp, got.sp);
				if (got.p !== want.p)
					$display("%0t: status exp %h got %h", $time, want.p, got.p);
				if (got.pc !== want.pc)
					$display("%0t: prog_counter exp %h got %h", $time, want.pc, got.pc);
				if (got.rd !== want.rd)
					$display("%0t: host_read_data exp %h got %h", $time, want.rd, got.rd);
				if (got !== want) n_errors++;
			end
		end
	end

	// Stall the result side at random, with calm stretches
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) calm = ~calm;
		if (!arst_n || calm) out_stall = 1'b0;
		else if (out_stall) out_stall = ($urandom_range(0, 99) < 60);
		else out_stall = ($urandom_range(0, 99) < 25);
	end

	// End the run if it hangs
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("tb_cpu6502_execute_unit NOT OK");
			$finish;
		end
	end

	task automatic idle_gap();
		int n, k;
		k = $urandom_range(0, 99);
		if (k < 65) n = 0;
		else if (k < 95) n = $urandom_range(1, 3);
		else n = $urandom_range(10, 40);
		in_valid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Drive one item at the falling edge and hold it until accepted
	task automatic send(logic [1:0] c, logic [5:0] op, logic [1:0] md,
			logic [15:0] opd, logic [7:0] ofs, logic [7:0] hd);
		int target;
		cmd = c;
		instr = op;
		mode = md;
		operand = opd;
		branch_offset = ofs;
		host_data = hd;
		in_valid = 1'b1;
		target = n_accepted + 1;
		while (n_accepted < target) @(negedge clk);
		typed_now = 1'b0;
		idle_gap();
	endtask

	task automatic add_row(cmd_t c, logic [5:0] op, logic [1:0] md, logic [15:0] opd,
			logic [7:0] ofs, bit typed, regs_t want);
		row_t rw;
		rw.c = c; rw.op = op; rw.md = md; rw.opd = opd; rw.ofs = ofs;
		rw.hd = 8'h00; rw.typed = typed; rw.want = want;
		dir_rows.push_back(rw);
	endtask

	initial begin
		logic [1:0] c;
		logic [5:0] op;
		logic [15:0] opd;
		int k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cmd = CMD_EXEC;
		instr = I_NOP;
		mode = MODE_IMM;
		operand = 16'd0;
		branch_offset = 8'd0;
		host_data = 8'd0;
		typed_now = 1'b0;
		calm = 1'b0;
		n_accepted = 0;
		n_errors = 0;
		n_cycles = 0;
		m_a = 8'd0; m_x = 8'd0; m_y = 8'd0;
		m_sp = SP_RESET; m_p = P_RESET; m_pc = 16'd0;

		// Directed table; typed rows hold values readable at a glance
		add_row(CMD_EXEC, I_NOP, MODE_IMM, 16'h0000, 8'h00, 1,
			'{8'h00, 8'h00, 8'h00, SP_RESET, P_RESET, 16'h0000, 8'h00});
		add_row(CMD_EXEC, I_LDA, MODE_IMM, 16'h0080, 8'h00, 1,
			'{8'h80, 8'h00, 8'h00, SP_RESET, 8'hA4, 16'h0000, 8'h00});
		add_row(CMD_EXEC, I_LDA, MODE_IMM, 16'hFF00, 8'h00, 1,
			'{8'h00, 8'h00, 8'h00, SP_RESET, 8'h26, 16'h0000, 8'h00});
		add_row(CMD_EXEC, I_LDX, MODE_IMM, 16'h00FF, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_LDY, 2'd2, 16'hF9FF, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_LDA, MODE_IMM, 16'h007F, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_ADC, MODE_IMM, 16'h0001, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_SBC, 2'd3, 16'h0123, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_ASL, MODE_ACC, 16'h0000, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_ROR, 2'd2, 16'h0042, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_BIT, MODE_IMM, 16'h0042, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_CMP, MODE_IMM, 16'h0000, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_BNE, MODE_IMM, 16'h0000, 8'h80, 0, '0);
		add_row(CMD_EXEC, I_BEQ, MODE_IMM, 16'h0000, 8'h7F, 0, '0);
		add_row(CMD_EXEC, I_JSR, MODE_IMM, 16'hFFFF, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_BRK, MODE_IMM, 16'h0000, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_RTI, MODE_IMM, 16'h0000, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_RTS, MODE_IMM, 16'h0000, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_TXS, MODE_IMM, 16'h0000, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_TSX, MODE_IMM, 16'h0000, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_SED, MODE_IMM, 16'h0000, 8'h00, 0, '0);
		add_row(CMD_EXEC, I_CLD, MODE_IMM, 16'h0000, 8'h00, 0, '0);
		add_row(CMD_EXEC, 6'd63, 2'd3, 16'hF9FF, 8'hFF, 0, '0);
		add_row(CMD_NONE, I_LDA, MODE_IMM, 16'h0011, 8'h00, 0, '0);
		add_row(CMD_HRD, I_NOP, MODE_IMM, 16'hF9FF, 8'h00, 0, '0);

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// The first row touches no RAM and sees the reset registers
		typed_now = dir_rows[0].typed;
		typed_want = dir_rows[0].want;
		send(dir_rows[0].c, dir_rows[0].op, dir_rows[0].md, dir_rows[0].opd,
			dir_rows[0].ofs, dir_rows[0].hd);

		// Load pages zero and one; every data and stack address used lands there
		for (int i = 0; i < LOAD_WORDS; i++)
			send(CMD_HWR, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
				16'(($urandom_range(0, 65535) & ~(RAM_WORDS - 1)) | i),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

		// Walk the rest of the directed table
		for (int i = 1; i < dir_rows.size(); i++) begin
			typed_now = dir_rows[i].typed;
			typed_want = dir_rows[i].want;
			send(dir_rows[i].c, dir_rows[i].op, dir_rows[i].md, dir_rows[i].opd,
				dir_rows[i].ofs, dir_rows[i].hd);
		end

		// Random instructions with some host traffic and unknown codes
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				in_valid = 1'b0;
				while (pending_regs.size() != 0) @(negedge clk);
			end
			k = $urandom_range(0, 99);
			if (k < 80) c = CMD_EXEC;
			else if (k < 90) c = CMD_HWR;
			else if (k < 97) c = CMD_HRD;
			else c = CMD_NONE;
			op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 51));
			// Keep the RAM index inside the loaded pages
			opd = 16'($urandom_range(0, 65535)) & ~16'(RAM_WORDS - LOAD_WORDS);
			send(c, op, 2'($urandom_range(0, 3)), opd,
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end

		// Drain and let the pipeline settle
		in_valid = 1'b0;
		while (pending_regs.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (n_errors == 0 && pending_regs.size() == 0) begin
			$display("tb_cpu6502_execute_unit OK");
		end else begin
			$display("tb_cpu6502_execute_unit NOT OK");
		end
		$finish;
	end

endmodule
